FILE: hw/rtl/mbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbb_pkg
// Types and constants shared by the monochrome bitmap blit engine.
// ----------------------------------------------------------------------------
package mbb_pkg;

	// one lane for each bit of a source byte
	localparam int LANES = 8;

	localparam int OP_W       = 2;
	localparam int BYTE_W     = 8;
	localparam int RADDR_W    = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	localparam int DIM_W      = 11;  // panel and image sizes
	localparam int ORG_W      = 10;  // origin coordinates
	localparam int POS_W      = 12;  // destination coordinate before clipping
	localparam int COL_W      = 8;   // source byte column
	localparam int RB_W       = 9;   // bytes per row
	localparam int PROD_W     = POS_W + RB_W;

	localparam logic [OP_W-1:0] OP_BLIT  = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

	localparam logic [BYTE_W-1:0] WHITE_BYTE = 8'hFF;

	// what every lane needs to place its bit
	typedef struct packed {
		logic             en;
		logic [DIM_W-1:0] c_base;
		logic [POS_W-1:0] dx_base;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] pw;
	} lane_ctx_t;

	// one lane's finding: sel picks the second destination byte
	typedef struct packed {
		logic       hit;
		logic       sel;
		logic [2:0] pos;
		logic       val;
	} lane_res_t;

	typedef struct packed {
		logic [BYTE_W-1:0] mask0;
		logic [BYTE_W-1:0] val0;
		logic [BYTE_W-1:0] mask1;
		logic [BYTE_W-1:0] val1;
	} merge_t;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_LANE  = 8'b0000_0010,
		S_RD0   = 8'b0000_0100,
		S_WR0   = 8'b0000_1000,
		S_WR1   = 8'b0001_0000,
		S_RDATA = 8'b0010_0000,
		S_CSIZE = 8'b0100_0000,
		S_FILL  = 8'b1000_0000
	} state_t;

endpackage

FILE: hw/rtl/mbb_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbb_item_if
// Command channel: source bytes, clear and read requests.
// ----------------------------------------------------------------------------
interface mbb_item_if;
	logic                          valid;
	logic                          ready;
	logic [mbb_pkg::OP_W-1:0]      op;
	logic [mbb_pkg::BYTE_W-1:0]    data_byte;
	logic                          first_of_image;
	logic [mbb_pkg::RADDR_W-1:0]   read_address;

	modport source (output valid, output op, output data_byte, output first_of_image,
		output read_address, input ready);
	modport sink (input valid, input op, input data_byte, input first_of_image,
		input read_address, output ready);
endinterface

FILE: hw/rtl/mbb_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbb_result_if
// Result channel: framebuffer bytes returned by reads.
// ----------------------------------------------------------------------------
interface mbb_result_if;
	logic                       valid;
	logic                       ready;
	logic [mbb_pkg::BYTE_W-1:0] read_data;

	modport source (output valid, output read_data, input ready);
	modport sink (input valid, input read_data, output ready);
endinterface

FILE: hw/rtl/mbb_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbb_lane
// Places one source bit: clips it and finds its destination byte and bit.
// ----------------------------------------------------------------------------
module mbb_lane (
	input  mbb_pkg::lane_ctx_t ctx,
	input  logic [2:0]         lane_idx,
	input  logic               src_bit,
	output mbb_pkg::lane_res_t res
);
	import mbb_pkg::*;

	logic [DIM_W-1:0] c;
	logic [POS_W-1:0] dx;

	always_comb begin
		c  = ctx.c_base + DIM_W'(lane_idx);
		dx = ctx.dx_base + POS_W'(lane_idx);
		res.hit = ctx.en && (c < ctx.image_width) && (dx < POS_W'(ctx.pw));
		res.sel = dx[POS_W-1:3] != ctx.dx_base[POS_W-1:3];
		res.pos = 3'd7 - dx[2:0];
		// a set source bit paints black
		res.val = ~src_bit;
	end

endmodule

FILE: hw/rtl/mbb_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbb_merge
// Gathers the lane results into write masks for the two destination bytes.
// ----------------------------------------------------------------------------
module mbb_merge (
	input  logic               clk,
	input  logic               load,
	input  mbb_pkg::lane_res_t lanes [mbb_pkg::LANES],
	output mbb_pkg::merge_t    merged_s2
);
	import mbb_pkg::*;

	merge_t m;

	always_comb begin
		m = '0;
		for (int l = 0; l < LANES; l++) begin
			if (lanes[l].hit) begin
				if (lanes[l].sel) begin
					m.mask1[lanes[l].pos] = 1'b1;
					m.val1[lanes[l].pos]  = lanes[l].val;
				end else begin
					m.mask0[lanes[l].pos] = 1'b1;
					m.val0[lanes[l].pos]  = lanes[l].val;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			merged_s2 <= m;
		end
	end

endmodule

FILE: hw/rtl/mbb_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbb_store
// Framebuffer memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mbb_store #(
	parameter int DEPTH = 131072,
	parameter int AW    = 17
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [mbb_pkg::BYTE_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [mbb_pkg::BYTE_W-1:0] rdata
);
	import mbb_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/mono_bitmap_blit_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_bitmap_blit_engine
// One-bit-per-pixel framebuffer with clipped image blit, clear and read.
// ----------------------------------------------------------------------------
// Usage: set panel size, origin and image size over the cfg port while idle,
// then send words on item: op blit carries one source byte (first_of_image
// restarts the row and column counters), op clear fills the panel area with
// data_byte, op read returns the byte at read_address on result.
// Eight lanes place the eight bits of a source byte together; the merged
// masks then read-modify-write at most two bytes through the single memory
// write port. A blit word passes the lane and read states, then a write
// state for each byte it touches. A read's byte passes the store's read
// register, then the result register; a clear writes row bytes times panel
// height bytes, one byte written per cycle. Reset sweeps the whole store
// to white, one byte per cycle; item.ready stays low meanwhile, cfg writes
// are taken at any time.
// The result register holds a finished byte while the receiver stalls; the
// block keeps taking blit and clear words, and a further read waits for it.
// ----------------------------------------------------------------------------
module mono_bitmap_blit_engine #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mbb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbb_pkg::CFG_DATA_W-1:0] cfg_data,
	mbb_item_if.sink                       item,
	mbb_result_if.source                   result
);
	import mbb_pkg::*;

	localparam int ROW_BYTES_MAX = (MAX_WIDTH + 7) / 8;
	localparam int STORE_DEPTH   = ROW_BYTES_MAX * MAX_HEIGHT;
	localparam int ADDR_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W         = ADDR_W + 1;

	// configuration
	logic [DIM_W-1:0] panel_width_q, panel_height_q, image_width_q, image_height_q;
	logic [ORG_W-1:0] origin_x_q, origin_y_q;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q, size_q;
	logic [BYTE_W-1:0] fill_q;
	logic [DIM_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             res_valid_q, rd_oob_q;
	logic [BYTE_W-1:0] res_data_q;

	// blit pipeline
	logic [BYTE_W-1:0] data_s1;
	logic [POS_W-1:0]  dy_s1;
	logic [DIM_W-1:0]  cbase_s1;
	logic [POS_W-1:0]  dxbase_s1;
	logic              en_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [RB_W-1:0]   colb_s2;
	logic [ADDR_W-1:0] addr0_q;

	logic [DIM_W-1:0]  pw, ph, row0, row_nxt;
	logic [RB_W-1:0]   row_bytes, src_rb, col_inc;
	logic [COL_W-1:0]  col0, col_nxt;
	logic [POS_W-1:0]  dy, dx_base;
	logic              active, rd_in_range, accept;
	logic [ADDR_W-1:0] addr0_c, addr1;

	lane_ctx_t         ctx;
	lane_res_t         lane_res [LANES];
	merge_t            merged;

	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [BYTE_W-1:0] mem_wdata, mem_rdata;

	assign item.ready       = (state_q == S_IDLE);
	assign accept           = item.valid && item.ready;
	assign result.valid     = res_valid_q;
	assign result.read_data = res_data_q;

	// effective panel size and counter stepping
	always_comb begin
		pw = (32'(panel_width_q) > 32'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : panel_width_q;
		ph = (32'(panel_height_q) > 32'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : panel_height_q;
		row_bytes = RB_W'((POS_W'(pw) + POS_W'(7)) >> 3);
		src_rb    = RB_W'((POS_W'(image_width_q) + POS_W'(7)) >> 3);

		row0    = item.first_of_image ? '0 : row_q;
		col0    = item.first_of_image ? '0 : col_q;
		active  = (src_rb != '0) && (row0 < image_height_q);
		col_inc = RB_W'(col0) + RB_W'(1);
		row_nxt = row0;
		col_nxt = col0;
		if (active) begin
			if (col_inc >= src_rb) begin
				col_nxt = '0;
				row_nxt = row0 + DIM_W'(1);
			end else begin
				col_nxt = col_inc[COL_W-1:0];
			end
		end

		dy      = POS_W'(origin_y_q) + POS_W'(row0);
		dx_base = POS_W'(origin_x_q) + POS_W'({col0, 3'b000});

		rd_in_range = 32'(item.read_address) < 32'(STORE_DEPTH);
		addr0_c = ADDR_W'(PROD_W'(prod_s2) + PROD_W'(colb_s2));
		addr1   = addr0_q + ADDR_W'(1);
	end

	assign ctx.en          = en_s1;
	assign ctx.c_base      = cbase_s1;
	assign ctx.dx_base     = dxbase_s1;
	assign ctx.image_width = image_width_q;
	assign ctx.pw          = pw;

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		mbb_lane u_lane (
			.ctx      (ctx),
			.lane_idx (3'(l)),
			.src_bit  (data_s1[LANES-1-l]),
			.res      (lane_res[l])
		);
	end

	mbb_merge u_merge (
		.clk       (clk),
		.load      (state_q == S_LANE),
		.lanes     (lane_res),
		.merged_s2 (merged)
	);

	// memory port steering
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr0_q;
		mem_wdata = (mem_rdata & ~merged.mask0) | (merged.val0 & merged.mask0);
		mem_re    = 1'b0;
		mem_raddr = addr0_q;
		unique case (state_q)
			S_IDLE: begin
				if (item.valid && item.op == OP_READ && rd_in_range) begin
					mem_re    = 1'b1;
					mem_raddr = ADDR_W'(item.read_address);
				end
			end
			S_RD0: begin
				mem_re    = merged.mask0 != '0;
				mem_raddr = addr0_c;
			end
			S_WR0: begin
				mem_we    = 1'b1;
				mem_re    = merged.mask1 != '0;
				mem_raddr = addr1;
			end
			S_WR1: begin
				mem_we    = 1'b1;
				mem_waddr = addr1;
				mem_wdata = (mem_rdata & ~merged.mask1) | (merged.val1 & merged.mask1);
			end
			S_FILL: begin
				mem_we    = cnt_q != size_q;
				mem_waddr = cnt_q[ADDR_W-1:0];
				mem_wdata = fill_q;
			end
			default: begin
			end
		endcase
	end

	mbb_store #(
		.DEPTH (STORE_DEPTH),
		.AW    (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_FILL;
			cnt_q          <= '0;
			size_q         <= CNT_W'(STORE_DEPTH);
			fill_q         <= WHITE_BYTE;
			row_q          <= '0;
			col_q          <= '0;
			res_valid_q    <= 1'b0;
			rd_oob_q       <= 1'b0;
			panel_width_q  <= DIM_W'(1024);
			panel_height_q <= DIM_W'(1024);
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			image_width_q  <= DIM_W'(1);
			image_height_q <= DIM_W'(1);
		end else begin
			if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PANEL_WIDTH:  panel_width_q  <= cfg_data;
					REG_PANEL_HEIGHT: panel_height_q <= cfg_data;
					REG_ORIGIN_X:     origin_x_q     <= cfg_data[ORG_W-1:0];
					REG_ORIGIN_Y:     origin_y_q     <= cfg_data[ORG_W-1:0];
					REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
					REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						unique case (item.op)
							OP_BLIT: begin
								row_q   <= row_nxt;
								col_q   <= col_nxt;
								state_q <= S_LANE;
							end
							OP_CLEAR: begin
								fill_q  <= item.data_byte;
								state_q <= S_CSIZE;
							end
							OP_READ: begin
								rd_oob_q <= !rd_in_range;
								state_q  <= S_RDATA;
							end
							default: begin
							end
						endcase
					end
				end
				S_LANE: state_q <= S_RD0;
				// lane 0 always lands in the first byte, so no first-byte hit
				// means no hit at all
				S_RD0: state_q <= (merged.mask0 != '0) ? S_WR0 : S_IDLE;
				S_WR0: state_q <= (merged.mask1 != '0) ? S_WR1 : S_IDLE;
				S_WR1: state_q <= S_IDLE;
				S_RDATA: begin
					if (!res_valid_q || result.ready) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_CSIZE: begin
					size_q  <= CNT_W'(20'(row_bytes) * 20'(ph));
					cnt_q   <= '0;
					state_q <= S_FILL;
				end
				S_FILL: begin
					if (cnt_q == size_q) begin
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.op == OP_BLIT) begin
			data_s1   <= item.data_byte;
			dy_s1     <= dy;
			cbase_s1  <= DIM_W'({col0, 3'b000});
			dxbase_s1 <= dx_base;
			en_s1     <= active && (dy < POS_W'(ph));
		end
		if (state_q == S_LANE) begin
			prod_s2 <= PROD_W'(dy_s1) * PROD_W'(row_bytes);
			colb_s2 <= dxbase_s1[POS_W-1:3];
		end
		if (state_q == S_RD0) begin
			addr0_q <= addr0_c;
		end
		if (state_q == S_RDATA && (!res_valid_q || result.ready)) begin
			res_data_q <= rd_oob_q ? '0 : mem_rdata;
		end
	end

`ifndef ASSERT_OFF
	a_no_write_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !item.ready)
		else $error("store written while taking words");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> (cnt_q <= size_q))
		else $error("fill counter ran past the clear size");

	a_wr0_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR0) |-> $past(state_q == S_RD0))
		else $error("first byte write without its read");

	a_wr1_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR1) |-> $past(state_q == S_WR0))
		else $error("second byte write without its read");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_RDATA))
		else $error("result raised outside a read");
`endif

endmodule

FILE: sim/mono_bitmap_blit_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_bitmap_blit_engine_tb
// Self-checking bench for the 1bpp blit engine. A directed table walks the
// reset state, clipping at the panel corner, size saturation, zero sizes,
// full clears and the unused opcode. Random register phases then stream
// images, clears and reads with bursty input and a stalling result side.
// Each read byte is checked, in the table against its listed byte, else against a shadow framebuffer kept here.
// ----------------------------------------------------------------------------
module mono_bitmap_blit_engine_tb;
	import mbb_pkg::*;

	localparam int MAX_W        = 1024;
	localparam int MAX_H        = 1024;
	localparam int FB_DEPTH     = ((MAX_W + 7) / 8) * MAX_H;
	localparam int N_PHASES     = 14;
	localparam int PHASE_ITEMS  = 118;
	localparam int CHEAP_CLEAR  = 2048;
	localparam int HOLD_CYCLES  = 600;
	// reset sweep and two full clears dominate the run time
	localparam int LIMIT_CYCLES = 3000000;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [OP_W-1:0]    op;
		logic [BYTE_W-1:0]  data;
		logic               first;
		logic [RADDR_W-1:0] addr;
	} cmd_t;

	typedef struct {
		bit                    is_reg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		cmd_t                  cmd;
		bit                    typed;
		logic [BYTE_W-1:0]     typed_byte;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mbb_item_if   cmd_ch();
	mbb_result_if rd_ch();

	mono_bitmap_blit_engine #(
		.MAX_WIDTH  (MAX_W),
		.MAX_HEIGHT (MAX_H)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (cmd_ch),
		.result    (rd_ch)
	);

	always #6 clk = ~clk;

	// shadow of the framebuffer, the blit counters and the registers
	logic [BYTE_W-1:0] fb_shadow [0:FB_DEPTH-1];
	int unsigned       src_row;
	int unsigned       src_col;
	logic [DIM_W-1:0]  sh_pw, sh_ph, sh_iw, sh_ih;
	logic [ORG_W-1:0]  sh_ox, sh_oy;

	logic [BYTE_W-1:0] bytes_due [$];
	plan_row_t         plan [$];

	int unsigned n_bad, n_checked, n_sent, n_useful, n_clears, n_blits, n_phases;
	int unsigned burst_left;
	bit          idle_on;
	bit          hold_req;

	function automatic int unsigned eff_w();
		return (sh_pw > MAX_W) ? MAX_W : int'(sh_pw);
	endfunction

	function automatic int unsigned eff_h();
		return (sh_ph > MAX_H) ? MAX_H : int'(sh_ph);
	endfunction

	function automatic int unsigned panel_bytes();
		int unsigned n;
		n = ((eff_w() + 7) / 8) * eff_h();
		return (n > FB_DEPTH) ? FB_DEPTH : n;
	endfunction

	// returns 1 when the byte belonged to the image (even if fully clipped)
	function automatic bit place_source_byte(logic [BYTE_W-1:0] v);
		int unsigned pw, rb, srb, dy, c, dx, a, b;
		bit          stop;
		pw   = eff_w();
		rb   = (pw + 7) / 8;
		srb  = (int'(sh_iw) + 7) / 8;
		stop = 1'b0;
		if (srb == 0 || src_row >= sh_ih)
			return 1'b0;
		dy = int'(sh_oy) + src_row;
		if (dy < eff_h()) begin
			for (b = 0; b < 8 && !stop; b++) begin
				c  = src_col * 8 + b;
				dx = int'(sh_ox) + c;
				if (c >= sh_iw || dx >= pw) begin
					stop = 1'b1;
				end else begin
					a = dy * rb + dx / 8;
					if (a >= FB_DEPTH)
						stop = 1'b1;
					else
						fb_shadow[a][7 - dx % 8] = ~v[7 - b];  // source 1 paints black
				end
			end
		end
		src_col++;
		if (src_col >= srb) begin
			src_col = 0;
			src_row++;
		end
		return 1'b1;
	endfunction

	function automatic void fill_shadow(logic [BYTE_W-1:0] v);
		int unsigned i, n;
		n = panel_bytes();
		for (i = 0; i < n; i++)
			fb_shadow[i] = v;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_PANEL_WIDTH:  sh_pw = val;
			REG_PANEL_HEIGHT: sh_ph = val;
			REG_ORIGIN_X:     sh_ox = val[ORG_W-1:0];
			REG_ORIGIN_Y:     sh_oy = val[ORG_W-1:0];
			REG_IMAGE_WIDTH:  sh_iw = val;
			REG_IMAGE_HEIGHT: sh_ih = val;
			default: ;
		endcase
	endfunction

	function automatic cmd_t make_cmd(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
		logic first, logic [RADDR_W-1:0] addr);
		cmd_t c;
		c.op    = op;
		c.data  = data;
		c.first = first;
		c.addr  = addr;
		return c;
	endfunction

	function automatic logic [RADDR_W-1:0] pick_addr();
		int unsigned n;
		n = panel_bytes();
		if (n == 0 || $urandom_range(0, 7) == 0)
			return RADDR_W'($urandom);
		return RADDR_W'($urandom_range(0, n - 1));
	endfunction

	function automatic logic [BYTE_W-1:0] rand_byte();
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	function automatic void add_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data, logic first,
		logic [RADDR_W-1:0] addr, bit typed, logic [BYTE_W-1:0] typed_byte);
		plan_row_t r;
		r.is_reg     = 1'b0;
		r.idx        = '0;
		r.val        = '0;
		r.cmd        = make_cmd(op, data, first, addr);
		r.typed      = typed;
		r.typed_byte = typed_byte;
		plan.push_back(r);
	endfunction

	function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		plan_row_t r;
		r.is_reg     = 1'b1;
		r.idx        = idx;
		r.val        = val;
		r.cmd        = make_cmd(OP_BLIT, '0, 1'b0, '0);
		r.typed      = 1'b0;
		r.typed_byte = '0;
		plan.push_back(r);
	endfunction

	function automatic void report_bad(string what, logic [BYTE_W-1:0] want,
		logic [BYTE_W-1:0] got);
		n_bad++;
		if (n_bad <= 10)
			$display("mismatch %0d at %0t: %s expected %02h got %02h", n_bad, $time, what,
				want, got);
	endfunction

	// caller lowers cfg_we once the group of writes is done
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		apply_reg(idx, val);
	endtask

	task automatic send_cmd(cmd_t c, bit typed, logic [BYTE_W-1:0] typed_byte);
		int unsigned gap;
		cmd_ch.valid          <= 1'b1;
		cmd_ch.op             <= c.op;
		cmd_ch.data_byte      <= c.data;
		cmd_ch.first_of_image <= c.first;
		cmd_ch.read_address   <= c.addr;
		do
			@(posedge clk);
		while (cmd_ch.ready !== 1'b1);
		n_sent++;
		case (c.op)
			OP_BLIT: begin
				n_blits++;
				if (c.first) begin
					src_row = 0;
					src_col = 0;
				end
				if (place_source_byte(c.data))
					n_useful++;
			end
			OP_CLEAR: begin
				fill_shadow(c.data);
				n_clears++;
				n_useful++;
			end
			OP_READ: begin
				bytes_due.push_back(typed ? typed_byte :
					((c.addr < FB_DEPTH) ? fb_shadow[c.addr] : 8'h00));
				n_useful++;
			end
			default: ;
		endcase
		if (idle_on) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 14);
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_read();
		send_cmd(make_cmd(OP_READ, rand_byte(), 1'($urandom_range(0, 1)), pick_addr()),
			1'b0, '0);
	endtask

	task automatic send_blit(logic first);
		send_cmd(make_cmd(OP_BLIT, rand_byte(), first, RADDR_W'($urandom)), 1'b0, '0);
	endtask

	task automatic send_clear();
		if (panel_bytes() <= CHEAP_CLEAR)
			send_cmd(make_cmd(OP_CLEAR, rand_byte(), 1'($urandom_range(0, 1)),
				RADDR_W'($urandom)), 1'b0, '0);
		else
			send_read();
	endtask

	task automatic send_noise();
		cmd_t c;
		c = make_cmd(OP_W'($urandom_range(0, 3)), rand_byte(), 1'($urandom_range(0, 1)),
			RADDR_W'($urandom));
		if (c.op == OP_CLEAR && panel_bytes() > CHEAP_CLEAR)
			c.op = OP_READ;
		send_cmd(c, 1'b0, '0);
	endtask

	// one image in row order, reads and the odd clear mixed in, sometimes cut short
	task automatic send_image();
		int unsigned n, k;
		n = ((int'(sh_iw) + 7) / 8) * sh_ih;
		if (n > 300)
			n = 300;
		if (n == 0)
			n = $urandom_range(1, 4);
		if ($urandom_range(0, 9) == 0)
			n = $urandom_range(1, n);
		for (k = 0; k < n; k++) begin
			send_blit(k == 0);
			if ($urandom_range(0, 5) == 0)
				send_read();
			if ($urandom_range(0, 199) == 0)
				send_clear();
		end
		repeat ($urandom_range(0, 2)) send_blit(1'b0);
		repeat ($urandom_range(1, 4)) send_read();
	endtask

	// a read behind all earlier work; once it returns the block is idle
	task automatic settle();
		send_read();
		cmd_ch.valid <= 1'b0;
		while (bytes_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic program_phase(int unsigned phase);
		int unsigned pw, ph, iw, ih, ox, oy;
		case ($urandom_range(0, 9))
			0: begin
				pw = 1024;
				ph = $urandom_range(1, 6);
			end
			1: begin
				pw = 2047;
				ph = $urandom_range(1, 4);
			end
			2: begin
				pw = $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
				ph = (pw == 0) ? $urandom_range(1, 40) : 0;
			end
			3: begin
				pw = $urandom_range(1, 16);
				ph = $urandom_range(1, 16);
			end
			default: begin
				pw = $urandom_range(1, 96);
				ph = $urandom_range(1, 48);
			end
		endcase
		case ($urandom_range(0, 5))
			0: ox = 0;
			1: ox = 1023;
			2: ox = 2047;  // upper bit dropped by the register
			default: ox = $urandom_range(0, (pw > 64) ? 64 : pw);
		endcase
		case ($urandom_range(0, 5))
			0: oy = 0;
			1: oy = 1023;
			default: oy = $urandom_range(0, (ph > 48) ? 48 : ph);
		endcase
		case ($urandom_range(0, 7))
			0: begin
				iw = 0;
				ih = $urandom_range(1, 4);
			end
			1: begin
				iw = 1024;
				ih = $urandom_range(1, 2);
			end
			2: begin
				iw = $urandom_range(1, 8);
				ih = $urandom_range(0, 12);
			end
			default: begin
				iw = $urandom_range(1, 40);
				ih = $urandom_range(1, 10);
			end
		endcase
		// widest image row the column counter has to hold
		if (phase == 3) begin
			iw = 2047;
			ih = 1;
		end
		write_reg(REG_PANEL_WIDTH, CFG_DATA_W'(pw));
		write_reg(REG_PANEL_HEIGHT, CFG_DATA_W'(ph));
		write_reg(REG_ORIGIN_X, CFG_DATA_W'(ox));
		write_reg(REG_ORIGIN_Y, CFG_DATA_W'(oy));
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(iw));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(ih));
		cfg_we <= 1'b0;
	endtask

	// result side: own stall pattern, a long hold on request, and the checker
	initial begin : result_sink
		int unsigned       hold_left, mode, mode_left, tick;
		logic [BYTE_W-1:0] want;
		hold_left = 0;
		mode      = 0;
		mode_left = 0;
		tick      = 0;
		rd_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rd_ch.valid === 1'b1 && rd_ch.ready === 1'b1) begin
				if (bytes_due.size() == 0) begin
					report_bad("word with nothing pending,", 8'hxx, rd_ch.read_data);
				end else begin
					want = bytes_due.pop_front();
					n_checked++;
					if (rd_ch.read_data !== want)
						report_bad("read_data", want, rd_ch.read_data);
				end
			end
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rd_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (mode)
					0: rd_ch.ready <= 1'b1;
					1: rd_ch.ready <= ($urandom_range(0, 99) >= 35);
					default: rd_ch.ready <= ((tick % 7) >= 3);
				endcase
			end
			tick++;
		end
	end

	initial begin : watchdog
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int unsigned i, phase, quota;
		bit          reg_open;

		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_index             <= '0;
		cfg_data              <= '0;
		cmd_ch.valid          <= 1'b0;
		cmd_ch.op             <= OP_BLIT;
		cmd_ch.data_byte      <= '0;
		cmd_ch.first_of_image <= 1'b0;
		cmd_ch.read_address   <= '0;

		for (i = 0; i < FB_DEPTH; i++)
			fb_shadow[i] = WHITE_BYTE;
		src_row    = 0;
		src_col    = 0;
		sh_pw      = DIM_W'(1024);
		sh_ph      = DIM_W'(1024);
		sh_ox      = '0;
		sh_oy      = '0;
		sh_iw      = DIM_W'(1);
		sh_ih      = DIM_W'(1);
		n_bad      = 0;
		n_checked  = 0;
		n_sent     = 0;
		n_useful   = 0;
		n_clears   = 0;
		n_blits    = 0;
		n_phases   = 0;
		burst_left = 0;
		idle_on    = 1'b1;
		hold_req   = 1'b0;
		reg_open   = 1'b0;

		// reset state: all white, 1024 x 1024 panel, 1 x 1 image at the origin
		add_item(OP_READ, 8'h00, 1'b0, 17'h00000, 1'b1, 8'hFF);
		add_item(OP_READ, 8'hFF, 1'b1, 17'h1FFFF, 1'b1, 8'hFF);
		add_item(OP_UNUSED, 8'hA5, 1'b1, 17'h00000, 1'b0, '0);
		add_item(OP_BLIT, 8'h80, 1'b1, 17'h00000, 1'b0, '0);
		add_item(OP_READ, 8'h00, 1'b0, 17'h00000, 1'b1, 8'h7F);
		// past the one-row image, ignored
		add_item(OP_BLIT, 8'hFF, 1'b0, 17'h1FFFF, 1'b0, '0);
		add_item(OP_READ, 8'h00, 1'b0, 17'h00000, 1'b1, 8'h7F);
		add_item(OP_BLIT, 8'h00, 1'b1, 17'h00000, 1'b0, '0);
		add_item(OP_READ, 8'h00, 1'b0, 17'h00000, 1'b1, 8'hFF);
		add_item(OP_CLEAR, 8'h00, 1'b0, 17'h00000, 1'b0, '0);
		add_item(OP_READ, 8'h00, 1'b0, 17'h1FFFF, 1'b1, 8'h00);
		// zero panel width: clear and blit touch nothing
		add_reg(REG_PANEL_WIDTH, 11'd0);
		add_item(OP_CLEAR, 8'h5A, 1'b0, 17'h00000, 1'b0, '0);
		add_item(OP_BLIT, 8'hFF, 1'b1, 17'h00000, 1'b0, '0);
		add_item(OP_READ, 8'h00, 1'b0, 17'h00000, 1'b1, 8'h00);
		// oversized panel saturates; image at the bottom right corner pixel
		add_reg(REG_PANEL_WIDTH, 11'd2047);
		add_reg(REG_PANEL_HEIGHT, 11'd2047);
		add_reg(REG_ORIGIN_X, 11'd2047);
		add_reg(REG_ORIGIN_Y, 11'd1023);
		add_reg(REG_IMAGE_WIDTH, 11'd16);
		add_reg(REG_IMAGE_HEIGHT, 11'd2);
		add_item(OP_BLIT, 8'h00, 1'b1, 17'h00000, 1'b0, '0);
		add_item(OP_READ, 8'h00, 1'b0, 17'h1FFFF, 1'b1, 8'h01);
		add_item(OP_BLIT, 8'hFF, 1'b0, 17'h00000, 1'b0, '0);
		add_item(OP_BLIT, 8'hFF, 1'b0, 17'h00000, 1'b0, '0);
		add_item(OP_READ, 8'h00, 1'b0, 17'h1FFFF, 1'b1, 8'h01);
		// zero image width: every source byte dropped
		add_reg(REG_IMAGE_WIDTH, 11'd0);
		add_item(OP_BLIT, 8'h00, 1'b1, 17'h00000, 1'b0, '0);
		add_item(OP_READ, 8'h00, 1'b0, 17'h1FFFF, 1'b1, 8'h01);
		add_item(OP_CLEAR, 8'hC3, 1'b0, 17'h00000, 1'b0, '0);
		add_item(OP_READ, 8'h00, 1'b0, 17'h00000, 1'b1, 8'hC3);
		add_item(OP_READ, 8'h00, 1'b0, 17'h1FFFF, 1'b1, 8'hC3);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[k]) begin
			if (plan[k].is_reg) begin
				if (!reg_open)
					settle();
				write_reg(plan[k].idx, plan[k].val);
				reg_open = 1'b1;
			end else begin
				if (reg_open) begin
					cfg_we   <= 1'b0;
					reg_open = 1'b0;
				end
				send_cmd(plan[k].cmd, plan[k].typed, plan[k].typed_byte);
			end
		end

		for (phase = 0; phase < N_PHASES; phase++) begin
			settle();
			program_phase(phase);
			n_phases++;
			idle_on = (phase % 4) != 2;
			// counters carry over the register change
			repeat ($urandom_range(1, 4)) send_blit(1'b0);
			if (phase == 5) begin
				// result side holds off while words keep coming, so the input backs up
				idle_on  = 1'b0;
				hold_req = 1'b1;
				repeat (40) begin
					if ($urandom_range(0, 3) == 0)
						send_blit(1'($urandom_range(0, 1)));
					else
						send_read();
				end
				idle_on = 1'b1;
			end
			quota = n_useful + PHASE_ITEMS;
			while (n_useful < quota) begin
				if ($urandom_range(0, 4) != 0)
					send_image();
				else
					repeat ($urandom_range(1, 6)) send_noise();
			end
		end

		settle();
		repeat (20) @(posedge clk);

		$display("covered %0d words: %0d source bytes, %0d clears, %0d reads checked",
			n_sent, n_blits, n_clears, n_checked);
		$display("%0d random register phases after the directed table, %0d mismatches",
			n_phases, n_bad);
		if (n_bad == 0 && bytes_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
